// ===== design/est_pkg.sv =====
// Package: constants, types and arctangent table for the placement matrix block.
package est_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int STEPS = 30;
  localparam int AW = 34;  // Q2.30 working width with headroom
  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [AW-1:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [AW-1:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [31:0] scale;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [1:0] row_index;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] col3;
    logic last_row;
  } out_t;

  function automatic logic signed [AW-1:0] atan_c(input int i);
    logic signed [AW-1:0] r;
    unique case (i)
      0: r = 34'sh3243F6A8;  1: r = 34'sh1DAC6705;  2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;  4: r = 34'sh03FEAB76;  5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;  7: r = 34'sh007FFF55;  8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD;  10: r = 34'sh000FFFFF; 11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF; 13: r = 34'sh0001FFFF; 14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF; 16: r = 34'sh00003FFF; 17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF; 19: r = 34'sh000007FF; 20: r = 34'sh000003FF;
      21: r = 34'sh000001FF; 22: r = 34'sh000000FF; 23: r = 34'sh0000007F;
      24: r = 34'sh0000003F; 25: r = 34'sh0000001F; 26: r = 34'sh0000000F;
      27: r = 34'sh00000008; 28: r = 34'sh00000004; 29: r = 34'sh00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q2.30 product rounded: floor((a*b + 2^29) / 2^30)
  function automatic logic signed [AW-1:0] qmul(input logic signed [AW-1:0] a,
                                                input logic signed [AW-1:0] b);
    logic signed [2*AW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[AW+29:30];
  endfunction
endpackage

// ===== design/est_if.sv =====
// Valid/ready channel interface carrying one payload.
interface est_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/euler_scale_translate_matrix.sv =====
// Top level: Euler angles, scale and position to a 4x4 placement matrix, one row per transaction.
// Path from input transaction to row 0: angle reduction, 30 CORDIC stages, products.
// Output: four rows per item on one channel; the pipeline itself takes an item per cycle while not
// stalled by a full buffer, and a 2-deep row buffer feeds the serializer.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module euler_scale_translate_matrix #(
  parameter int FRAC_BITS = est_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  est_if.sink in_ch,
  est_if.source out_ch
);
  import est_pkg::*;

  localparam int NS = 2 + STEPS + 5;  // pipeline stages

  typedef logic signed [AW-1:0] w_t;

  logic adv;
  logic [NS-1:0] v;
  // per-stage registers
  w_t x [3][NS];
  w_t y [3][NS];
  w_t z [3][NS];
  logic ng [3][NS];
  logic signed [31:0] sc [NS];
  logic [31:0] px [NS], py [NS], pz [NS];
  w_t m [9][NS];

  // output buffer: two entries of full matrices
  logic [1:0] cnt;
  logic wp, rp;
  logic [1:0] row;
  logic signed [31:0] bm [2][9];
  logic [31:0] bp [2][3];

  assign adv = !v[NS-1] || (cnt != 2'd2) || 1'b0;
  assign in_ch.ready = adv;

  // input range needs at most one 2*pi step
  function automatic w_t reduce(input logic [15:0] a);
    w_t t;
    t = w_t'($signed(a)) <<< 18;
    if (t > PI_Q30) t = t - TWO_PI_Q30;
    else if (t < -PI_Q30) t = t + TWO_PI_Q30;
    return t;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [AW+31:0] p);
    logic signed [AW+31:0] q;
    q = (p + (66'sd1 <<< 29)) >>> 30;
    if (q > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -66'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  logic [15:0] ang [3];
  assign ang[0] = in_ch.data.pitch;
  assign ang[1] = in_ch.data.yaw;
  assign ang[2] = in_ch.data.roll;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[NS-2:0], in_ch.valid};
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        z[k][0] <= reduce(ang[k]);
        // fold
        if (z[k][0] > HALF_PI_Q30) begin
          z[k][1] <= PI_Q30 - z[k][0]; ng[k][1] <= 1'b1;
        end else if (z[k][0] < -HALF_PI_Q30) begin
          z[k][1] <= -PI_Q30 - z[k][0]; ng[k][1] <= 1'b1;
        end else begin
          z[k][1] <= z[k][0]; ng[k][1] <= 1'b0;
        end
        x[k][1] <= GAIN_INV;
        y[k][1] <= '0;
        for (int i = 0; i < STEPS; i++) begin
          if (!z[k][i+1][AW-1]) begin
            x[k][i+2] <= x[k][i+1] - (y[k][i+1] >>> i);
            y[k][i+2] <= y[k][i+1] + (x[k][i+1] >>> i);
            z[k][i+2] <= z[k][i+1] - atan_c(i);
          end else begin
            x[k][i+2] <= x[k][i+1] + (y[k][i+1] >>> i);
            y[k][i+2] <= y[k][i+1] - (x[k][i+1] >>> i);
            z[k][i+2] <= z[k][i+1] + atan_c(i);
          end
          ng[k][i+2] <= ng[k][i+1];
        end
        x[k][STEPS+2] <= ng[k][STEPS+1] ? -x[k][STEPS+1] : x[k][STEPS+1];
        y[k][STEPS+2] <= y[k][STEPS+1];
      end
      sc[0] <= in_ch.data.scale; px[0] <= in_ch.data.pos_x;
      py[0] <= in_ch.data.pos_y; pz[0] <= in_ch.data.pos_z;
      for (int s = 1; s < NS; s++) begin
        sc[s] <= sc[s-1]; px[s] <= px[s-1]; py[s] <= py[s-1]; pz[s] <= pz[s-1];
      end
      // S = STEPS+2 holds cos (x) / sin (y); k: 0 pitch, 1 yaw, 2 roll
      // stage A: XZ = X*Z
      begin
        automatic w_t cp = x[0][STEPS+2], sp = y[0][STEPS+2];
        automatic w_t cy = x[1][STEPS+2], sy = y[1][STEPS+2];
        automatic w_t cr = x[2][STEPS+2], sr = y[2][STEPS+2];
        m[0][STEPS+3] <= qmul(ONE_Q30, cr);
        m[1][STEPS+3] <= qmul(ONE_Q30, sr);
        m[2][STEPS+3] <= '0;
        m[3][STEPS+3] <= qmul(cp, -sr);
        m[4][STEPS+3] <= qmul(cp, cr);
        m[5][STEPS+3] <= sp;
        m[6][STEPS+3] <= qmul(-sp, -sr);
        m[7][STEPS+3] <= qmul(-sp, cr);
        m[8][STEPS+3] <= cp;
        // keep yaw values
        x[1][STEPS+3] <= cy; y[1][STEPS+3] <= sy;
      end
      // stage B: R = XZ*Y
      for (int r = 0; r < 3; r++) begin
        m[3*r+0][STEPS+4] <= qmul(m[3*r][STEPS+3], x[1][STEPS+3])
                           + qmul(m[3*r+2][STEPS+3], y[1][STEPS+3]);
        m[3*r+1][STEPS+4] <= m[3*r+1][STEPS+3];
        m[3*r+2][STEPS+4] <= qmul(m[3*r][STEPS+3], -y[1][STEPS+3])
                           + qmul(m[3*r+2][STEPS+3], x[1][STEPS+3]);
      end
      for (int e = 0; e < 9; e++) begin
        m[e][STEPS+5] <= m[e][STEPS+4];
        m[e][NS-1] <= m[e][STEPS+5];
      end
    end
  end

  // output side
  logic take, give;
  logic [3:0] base;
  assign take = adv && v[NS-1];
  assign give = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt != 2'd0;
  assign base = {2'b00, row} + {1'b0, row, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; wp <= 1'b0; rp <= 1'b0; row <= '0;
    end else begin
      if (take) wp <= !wp;
      if (give) begin
        row <= row + 2'd1;
        if (row == 2'd3) rp <= !rp;
      end
      cnt <= cnt + {1'b0, take} - {1'b0, give && row == 2'd3};
    end
    if (take) begin
      for (int e = 0; e < 9; e++)
        bm[wp][e] <= sat(66'(m[e][NS-1]) * 66'(sc[NS-1]));
      bp[wp][0] <= px[NS-1]; bp[wp][1] <= py[NS-1]; bp[wp][2] <= pz[NS-1];
    end
  end

  always_comb begin
    out_ch.data.row_index = row;
    out_ch.data.last_row = row == 2'd3;
    if (row == 2'd3) begin
      out_ch.data.col0 = bp[rp][0];
      out_ch.data.col1 = bp[rp][1];
      out_ch.data.col2 = bp[rp][2];
      out_ch.data.col3 = 32'(64'd1 << FRAC_BITS);
    end else begin
      out_ch.data.col0 = bm[rp][base];
      out_ch.data.col1 = bm[rp][base + 4'd1];
      out_ch.data.col2 = bm[rp][base + 4'd2];
      out_ch.data.col3 = '0;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("buffer overflow");
  a_row: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 |-> row == 2'd0) else $error("row not at start");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(row)) else $error("row moved");
endmodule
